FILE: rtl/mi3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg: shared types and constants for the 3x3 matrix inverse
// Element and result types, cofactor index table, pipeline depths.
// ----------------------------------------------------------------------------
package mi3_pkg;

	localparam int ELEM_W    = 32;
	localparam int N_ELEM    = 9;
	localparam int COF_W     = 64;
	localparam int DMAG_W    = 97;
	localparam int REM_W     = DMAG_W + 1;
	localparam int DIV_STEPS = 32;
	localparam int FRONT_LAT = 6;
	localparam int LANE_LAT  = DIV_STEPS + 2;
	localparam int PIPE_LAT  = FRONT_LAT + LANE_LAT + 1;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic signed [COF_W-1:0]  cof_t;
	typedef logic [COF_W-1:0]         mag_t;
	typedef logic [DMAG_W-1:0]        dmag_t;
	typedef logic [REM_W-1:0]         rem_t;
	typedef logic [ELEM_W-1:0]        quo_t;

	localparam elem_t SAT_POS = 32'h7FFF_FFFF;
	localparam elem_t SAT_NEG = 32'h8000_0000;

	// cofactor k = t[a]*t[b] - t[c]*t[d], element index k = row + 3*col
	localparam int COF_IDX [N_ELEM][4] = '{
		'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
		'{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
		'{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
	};

	// determinant expands along column 0: n0*t0 + n3*t1 + n6*t2
	localparam int DET_COF [3] = '{0, 3, 6};

	typedef struct packed {
		elem_t a00;
		elem_t a10;
		elem_t a20;
		elem_t a01;
		elem_t a11;
		elem_t a21;
		elem_t a02;
		elem_t a12;
		elem_t a22;
	} mi3_in_t;

	typedef struct packed {
		elem_t r0;
		elem_t r1;
		elem_t r2;
		elem_t r3;
		elem_t r4;
		elem_t r5;
		elem_t r6;
		elem_t r7;
		elem_t r8;
		logic  singular;
		logic  overflow;
	} mi3_out_t;

endpackage

FILE: rtl/mi3_cof.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_cof: cofactor stage
// Eighteen 32x32 products in s1, nine exact 64-bit cofactors in s2.
// ----------------------------------------------------------------------------
module mi3_cof import mi3_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  elem_t t [N_ELEM],
	output cof_t  n_s2 [N_ELEM],
	output elem_t t_s2 [3]
);

	cof_t  pa_s1 [N_ELEM];
	cof_t  pb_s1 [N_ELEM];
	elem_t t_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N_ELEM; k++) begin
				pa_s1[k] <= t[COF_IDX[k][0]] * t[COF_IDX[k][1]];
				pb_s1[k] <= t[COF_IDX[k][2]] * t[COF_IDX[k][3]];
				n_s2[k]  <= pa_s1[k] - pb_s1[k];
			end
			for (int i = 0; i < 3; i++) begin
				t_s1[i] <= t[i];
				t_s2[i] <= t_s1[i];
			end
		end
	end

endmodule

FILE: rtl/mi3_det.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_det: determinant and magnitude stage
// Split 64x32 products (s3), terms (s4), sum (s5), sign and magnitude (s6).
// ----------------------------------------------------------------------------
module mi3_det import mi3_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  cof_t  n_s2 [N_ELEM],
	input  elem_t t_s2 [3],
	output mag_t  m_s6 [N_ELEM],
	output logic  nneg_s6 [N_ELEM],
	output dmag_t dmag_s6,
	output logic  dneg_s6,
	output logic  sing_s6
);

	logic signed [COF_W:0]    lo_s3 [3];
	logic signed [COF_W-1:0]  hi_s3 [3];
	logic signed [DMAG_W-1:0] term_s4 [3];
	logic signed [DMAG_W-1:0] det_s5;
	cof_t n_s3 [N_ELEM];
	cof_t n_s4 [N_ELEM];
	cof_t n_s5 [N_ELEM];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				lo_s3[i]   <= $signed({1'b0, n_s2[DET_COF[i]][31:0]}) * t_s2[i];
				hi_s3[i]   <= $signed(n_s2[DET_COF[i]][63:32]) * t_s2[i];
				term_s4[i] <= (DMAG_W'(hi_s3[i]) <<< 32) + DMAG_W'(lo_s3[i]);
			end
			det_s5  <= term_s4[0] + term_s4[1] + term_s4[2];
			dneg_s6 <= det_s5[DMAG_W-1];
			dmag_s6 <= det_s5[DMAG_W-1] ? dmag_t'(-det_s5) : dmag_t'(det_s5);
			sing_s6 <= (det_s5 == '0);
			for (int k = 0; k < N_ELEM; k++) begin
				n_s3[k]    <= n_s2[k];
				n_s4[k]    <= n_s3[k];
				n_s5[k]    <= n_s4[k];
				m_s6[k]    <= n_s5[k][COF_W-1] ? mag_t'(-n_s5[k]) : mag_t'(n_s5[k]);
				nneg_s6[k] <= n_s5[k][COF_W-1];
			end
		end
	end

endmodule

FILE: rtl/mi3_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_lane: one divider lane
// Pipelined restoring division (|cof| << 32) / |det|, one quotient bit per
// stage, then signed saturation to a 32-bit signed result scaled by 2^32 (signed Q0.32).
// ----------------------------------------------------------------------------
module mi3_lane import mi3_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  mag_t  m,
	input  logic  neg,
	input  dmag_t dmag_in,
	input  dmag_t dmag_pipe [DIV_STEPS],
	output elem_t r,
	output logic  sat
);

	rem_t rem_q [DIV_STEPS];
	quo_t quo_q [DIV_STEPS+1];
	logic big_q [DIV_STEPS+1];
	logic neg_q [DIV_STEPS+1];
	rem_t r2 [DIV_STEPS];
	logic ge [DIV_STEPS];

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		assign r2[j] = {rem_q[j][REM_W-2:0], 1'b0};
		assign ge[j] = (r2[j] >= rem_t'(dmag_pipe[j]));
	end

	// quotient at or above 2^32 exactly when |cof| >= |det|
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= rem_t'(m);
			quo_q[0] <= '0;
			big_q[0] <= (dmag_t'(m) >= dmag_in);
			neg_q[0] <= neg;
			for (int j = 1; j < DIV_STEPS; j++) begin
				rem_q[j] <= ge[j-1] ? r2[j-1] - rem_t'(dmag_pipe[j-1]) : r2[j-1];
			end
			for (int j = 0; j < DIV_STEPS; j++) begin
				quo_q[j+1] <= {quo_q[j][ELEM_W-2:0], ge[j]};
				big_q[j+1] <= big_q[j];
				neg_q[j+1] <= neg_q[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!neg_q[DIV_STEPS]) begin
				if (big_q[DIV_STEPS] || quo_q[DIV_STEPS][ELEM_W-1]) begin
					r   <= SAT_POS;
					sat <= 1'b1;
				end else begin
					r   <= elem_t'(quo_q[DIV_STEPS]);
					sat <= 1'b0;
				end
			end else begin
				if (big_q[DIV_STEPS] || (quo_q[DIV_STEPS][ELEM_W-1]
				    && (quo_q[DIV_STEPS][ELEM_W-2:0] != '0))) begin
					r   <= SAT_NEG;
					sat <= 1'b1;
				end else begin
					r   <= elem_t'(-quo_q[DIV_STEPS]);
					sat <= 1'b0;
				end
			end
		end
	end

endmodule

FILE: rtl/matrix_inverse_3x3.sv
`timescale 1ns / 1ps
// Throughput: one matrix per cycle; the whole pipeline advances together and
// holds only while a finished result waits at the output register.
// Reset: arst_n clears all stage valid bits; the pipeline is then empty and
// req_ready is high right after reset.
// ----------------------------------------------------------------------------
// matrix_inverse_3x3: 3x3 matrix inverse by adjugate over determinant
// Exact cofactors and determinant, nine parallel divider lanes, and a merge
// stage that applies the singular case and collects the overflow flag.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 import mi3_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  mi3_in_t  req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output mi3_out_t rsp
);

	// Stage map:
	//   s1      18 element products
	//   s2      cofactors
	//   s3..s6  determinant, its sign and magnitude, cofactor magnitudes
	//   lanes   entry compare, 32 quotient-bit steps, saturation
	//   out     merge and output register

	logic en;
	logic [PIPE_LAT-1:0] vld_q;

	elem_t t [N_ELEM];
	cof_t  n_s2 [N_ELEM];
	elem_t t_s2 [3];
	mag_t  m_s6 [N_ELEM];
	logic  nneg_s6 [N_ELEM];
	dmag_t dmag_s6;
	logic  dneg_s6;
	logic  sing_s6;

	dmag_t dmag_pipe_q [DIV_STEPS];
	logic  sing_pipe_q [LANE_LAT];

	elem_t r_lane [N_ELEM];
	logic [N_ELEM-1:0] sat_lane;

	mi3_out_t merge_d;
	mi3_out_t rsp_q;

	// Advance everything when the output register is empty or being drained.
	assign en        = !vld_q[PIPE_LAT-1] || rsp_ready;
	assign req_ready = en;
	assign rsp_valid = vld_q[PIPE_LAT-1];
	assign rsp       = rsp_q;

	// Column-major element order, matching the field order of the request.
	assign t[0] = req.a00;
	assign t[1] = req.a10;
	assign t[2] = req.a20;
	assign t[3] = req.a01;
	assign t[4] = req.a11;
	assign t[5] = req.a21;
	assign t[6] = req.a02;
	assign t[7] = req.a12;
	assign t[8] = req.a22;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], req_valid};
		end
	end

	mi3_cof u_cof (
		.clk  (clk),
		.en   (en),
		.t    (t),
		.n_s2 (n_s2),
		.t_s2 (t_s2)
	);

	mi3_det u_det (
		.clk     (clk),
		.en      (en),
		.n_s2    (n_s2),
		.t_s2    (t_s2),
		.m_s6    (m_s6),
		.nneg_s6 (nneg_s6),
		.dmag_s6 (dmag_s6),
		.dneg_s6 (dneg_s6),
		.sing_s6 (sing_s6)
	);

	// Share one divisor delay line across all lanes; the singular flag rides
	// alongside so it lines up with the lane results.
	always_ff @(posedge clk) begin
		if (en) begin
			dmag_pipe_q[0] <= dmag_s6;
			for (int j = 1; j < DIV_STEPS; j++) begin
				dmag_pipe_q[j] <= dmag_pipe_q[j-1];
			end
			sing_pipe_q[0] <= sing_s6;
			for (int j = 1; j < LANE_LAT; j++) begin
				sing_pipe_q[j] <= sing_pipe_q[j-1];
			end
		end
	end

	for (genvar k = 0; k < N_ELEM; k++) begin : g_lane
		mi3_lane u_lane (
			.clk       (clk),
			.en        (en),
			.m         (m_s6[k]),
			.neg       (nneg_s6[k] ^ dneg_s6),
			.dmag_in   (dmag_s6),
			.dmag_pipe (dmag_pipe_q),
			.r         (r_lane[k]),
			.sat       (sat_lane[k])
		);
	end

	// Merge: a zero determinant forces zero results and drops overflow.
	always_comb begin
		merge_d.r0       = sing_pipe_q[LANE_LAT-1] ? '0 : r_lane[0];
		merge_d.r1       = sing_pipe_q[LANE_LAT-1] ? '0 : r_lane[1];
		merge_d.r2       = sing_pipe_q[LANE_LAT-1] ? '0 : r_lane[2];
		merge_d.r3       = sing_pipe_q[LANE_LAT-1] ? '0 : r_lane[3];
		merge_d.r4       = sing_pipe_q[LANE_LAT-1] ? '0 : r_lane[4];
		merge_d.r5       = sing_pipe_q[LANE_LAT-1] ? '0 : r_lane[5];
		merge_d.r6       = sing_pipe_q[LANE_LAT-1] ? '0 : r_lane[6];
		merge_d.r7       = sing_pipe_q[LANE_LAT-1] ? '0 : r_lane[7];
		merge_d.r8       = sing_pipe_q[LANE_LAT-1] ? '0 : r_lane[8];
		merge_d.singular = sing_pipe_q[LANE_LAT-1];
		merge_d.overflow = !sing_pipe_q[LANE_LAT-1] && (|sat_lane);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_q <= merge_d;
		end
	end

`ifndef ASSERT_OFF
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> vld_q[0])
		else $error("accepted transaction did not enter stage s1");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("request taken while output is stalled");

	a_singular_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.singular |-> !rsp.overflow && rsp.r0 == '0 && rsp.r4 == '0
		&& rsp.r8 == '0)
		else $error("singular result carries data or overflow");
`endif

endmodule
